FILE: rtl/nmf_pkg.sv
package nmf_pkg;

   // Field widths of the sample, coefficient and phase words.
   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 18;
   localparam int PHASE_W      = 32;
   localparam int TAP_COUNT_W  = 7;
   localparam int COEF_SEL_W   = 6;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 32;

   // Rotator word: Q1.30 plus guard bits so no step can overflow.
   localparam int CORDIC_W     = 33;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_K_W   = 4;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032875;

   // Unity tap in Q1.16.
   localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_SEL   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_VALUE = 8'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [CORDIC_W-1:0] cordic_val_type;

   typedef struct packed {
      sample_type re;
      sample_type im;
   } cplx_type;

   // Coefficient write broadcast to the tap cells.
   typedef struct packed {
      logic                  en;
      logic [COEF_SEL_W-1:0] sel;
      coef_type              value;
   } coef_wr_type;

   // Arc tangent of 2^-k in 2^-32 turns.
   function automatic cordic_val_type cordic_angle(input logic [CORDIC_K_W-1:0] k);
      case (k)
         4'd0:    return 33'sd536870912;
         4'd1:    return 33'sd316933406;
         4'd2:    return 33'sd167458907;
         4'd3:    return 33'sd85004757;
         4'd4:    return 33'sd42667331;
         4'd5:    return 33'sd21354465;
         4'd6:    return 33'sd10679838;
         4'd7:    return 33'sd5340245;
         4'd8:    return 33'sd2670163;
         4'd9:    return 33'sd1335087;
         4'd10:   return 33'sd667544;
         4'd11:   return 33'sd333772;
         4'd12:   return 33'sd166886;
         4'd13:   return 33'sd83443;
         4'd14:   return 33'sd41722;
         default: return 33'sd20861;
      endcase
   endfunction

   // Clamp a sign-extended value to the sample range.
   function automatic sample_type sat_sample(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd32767;
      lo = -64'sd32768;
      if (v > hi) begin
         return 16'sd32767;
      end else if (v < lo) begin
         return -16'sd32768;
      end
      return sample_type'(v);
   endfunction

endpackage

FILE: rtl/nmf_req_if.sv
interface nmf_req_if;
   import nmf_pkg::*;

   logic                valid;
   logic                ready;
   sample_type          sample_i;
   sample_type          sample_q;
   logic                block_start;
   logic [PHASE_W-1:0]  sample_index;

   modport source (output valid, output sample_i, output sample_q, output block_start,
                   output sample_index, input ready);
   modport sink   (input valid, input sample_i, input sample_q, input block_start,
                   input sample_index, output ready);
endinterface

FILE: rtl/nmf_rsp_if.sv
interface nmf_rsp_if;
   import nmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type out_i;
   sample_type out_q;

   modport source (output valid, output out_i, output out_q, input ready);
   modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

FILE: rtl/nmf_csr_if.sv
interface nmf_csr_if;
   import nmf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/nmf_cordic.sv
module nmf_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [nmf_pkg::PHASE_W-1:0] phase,
   output logic                   done,
   output nmf_pkg::cordic_val_type cos_val,
   output nmf_pkg::cordic_val_type sin_val
);
   import nmf_pkg::*;

   localparam logic [CORDIC_K_W-1:0] LAST_STEP = CORDIC_K_W'(CORDIC_STEPS - 1);

   cordic_val_type          x_ff, x_in;
   cordic_val_type          y_ff, y_in;
   cordic_val_type          z_ff, z_in;
   cordic_val_type          cos_ff, cos_in;
   cordic_val_type          sin_ff, sin_in;
   logic [CORDIC_K_W-1:0]   k_ff, k_in;
   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic                    flip_ff, flip_in;

   logic                    fold;
   logic [PHASE_W-1:0]      folded;
   cordic_val_type          x_sh;
   cordic_val_type          y_sh;
   cordic_val_type          ang;

   // Fold the second and third quadrants onto the first and fourth.
   always_comb begin
      fold   = phase[PHASE_W-1] ^ phase[PHASE_W-2];
      folded = {phase[PHASE_W-1] ^ fold, phase[PHASE_W-2:0]};
      x_sh   = x_ff >>> k_ff;
      y_sh   = y_ff >>> k_ff;
      ang    = cordic_angle(k_ff);
   end

   // One rotation step per cycle; the direction follows the residual angle.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      fin_in  = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CORDIC_W'(signed'(folded));
         k_in    = '0;
         busy_in = 1'b1;
         flip_in = fold;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + ang;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == LAST_STEP) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   // Undo the fold on the way out.
   always_comb begin
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      done_in = fin_ff;
      if (fin_ff) begin
         cos_in = flip_ff ? -x_ff : x_ff;
         sin_in = flip_ff ? -y_ff : y_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      if (reset) begin
         k_ff    <= '0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         k_ff    <= k_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

FILE: rtl/nmf_mixer.sv
module nmf_mixer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  nmf_pkg::cplx_type       smp,
   input  nmf_pkg::cordic_val_type cos_val,
   input  nmf_pkg::cordic_val_type sin_val,
   output logic                    valid,
   output nmf_pkg::cplx_type       mix
);
   import nmf_pkg::*;

   localparam int PROD_W    = SAMPLE_W + CORDIC_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int MIX_SHIFT = 30;
   localparam logic signed [SUM_W-1:0] MIX_ROUND = SUM_W'(2 ** (MIX_SHIFT - 1));

   logic signed [PROD_W-1:0] p_ic_ff, p_ic_in;
   logic signed [PROD_W-1:0] p_qs_ff, p_qs_in;
   logic signed [PROD_W-1:0] p_qc_ff, p_qc_in;
   logic signed [PROD_W-1:0] p_is_ff, p_is_in;
   logic                     v1_ff, v1_in;
   logic                     v2_ff, v2_in;
   cplx_type                 mix_ff, mix_in;

   logic signed [SUM_W-1:0]  sum_i;
   logic signed [SUM_W-1:0]  sum_q;

   // First stage: the four partial products of the conjugate multiply.
   always_comb begin
      p_ic_in = PROD_W'(signed'(smp.re)) * PROD_W'(cos_val);
      p_qs_in = PROD_W'(signed'(smp.im)) * PROD_W'(sin_val);
      p_qc_in = PROD_W'(signed'(smp.im)) * PROD_W'(cos_val);
      p_is_in = PROD_W'(signed'(smp.re)) * PROD_W'(sin_val);
      v1_in   = start;
   end

   // Second stage: combine, round to nearest, drop 30 bits and clamp.
   always_comb begin
      sum_i     = SUM_W'(p_ic_ff) + SUM_W'(p_qs_ff) + MIX_ROUND;
      sum_q     = SUM_W'(p_qc_ff) - SUM_W'(p_is_ff) + MIX_ROUND;
      mix_in.re = sat_sample(64'(sum_i >>> MIX_SHIFT));
      mix_in.im = sat_sample(64'(sum_q >>> MIX_SHIFT));
      v2_in     = v1_ff;
   end

   always_ff @(posedge clock) begin
      p_ic_ff <= p_ic_in;
      p_qs_ff <= p_qs_in;
      p_qc_ff <= p_qc_in;
      p_is_ff <= p_is_in;
      mix_ff  <= mix_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   assign valid = v2_ff;
   assign mix   = mix_ff;

endmodule

FILE: rtl/nmf_tap_cell.sv
module nmf_tap_cell #(
   parameter int IDX   = 0,
   parameter int ACC_W = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic                          clear,
   input  nmf_pkg::cplx_type             x_in,
   output nmf_pkg::cplx_type             x_out,
   input  nmf_pkg::coef_wr_type          coef_wr,
   input  logic [nmf_pkg::TAP_COUNT_W-1:0] tap_count,
   input  logic signed [ACC_W-1:0]       sum_i_in,
   input  logic signed [ACC_W-1:0]       sum_q_in,
   output logic signed [ACC_W-1:0]       sum_i_out,
   output logic signed [ACC_W-1:0]       sum_q_out
);
   import nmf_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam bit SEL_OK = IDX < (2 ** COEF_SEL_W);
   localparam logic [COEF_SEL_W-1:0]  SEL_V = COEF_SEL_W'(IDX);
   localparam logic [TAP_COUNT_W+1:0] IDX_V = (TAP_COUNT_W + 2)'(IDX);
   localparam coef_type COEF_RST = (IDX == 0) ? COEF_ONE : '0;

   cplx_type                 x_ff, x_nxt_in;
   coef_type                 coef_ff, coef_in;
   logic signed [PROD_W-1:0] prod_i_ff, prod_i_in;
   logic signed [PROD_W-1:0] prod_q_ff, prod_q_in;
   logic signed [ACC_W-1:0]  sum_i_ff, sum_i_in_nxt;
   logic signed [ACC_W-1:0]  sum_q_ff, sum_q_in_nxt;
   logic                     active;

   // History slot: shifts one place per sample, cleared at a block start.
   always_comb begin
      x_nxt_in = x_ff;
      if (shift_en) begin
         x_nxt_in = clear ? '0 : x_in;
      end
   end

   // Coefficient slot: takes a write addressed to this tap.
   always_comb begin
      coef_in = coef_ff;
      if (SEL_OK && coef_wr.en && (coef_wr.sel == SEL_V)) begin
         coef_in = coef_wr.value;
      end
   end

   // Tap product, zero when this tap lies beyond the taps in use.
   always_comb begin
      active    = {2'b00, tap_count} > IDX_V;
      prod_i_in = '0;
      prod_q_in = '0;
      if (active) begin
         prod_i_in = PROD_W'(signed'(x_ff.re)) * PROD_W'(coef_ff);
         prod_q_in = PROD_W'(signed'(x_ff.im)) * PROD_W'(coef_ff);
      end
      sum_i_in_nxt = sum_i_in + ACC_W'(prod_i_ff);
      sum_q_in_nxt = sum_q_in + ACC_W'(prod_q_ff);
   end

   always_ff @(posedge clock) begin
      prod_i_ff <= prod_i_in;
      prod_q_ff <= prod_q_in;
      sum_i_ff  <= sum_i_in_nxt;
      sum_q_ff  <= sum_q_in_nxt;
      if (reset) begin
         x_ff    <= '0;
         coef_ff <= COEF_RST;
      end else begin
         x_ff    <= x_nxt_in;
         coef_ff <= coef_in;
      end
   end

   assign x_out     = x_ff;
   assign sum_i_out = sum_i_ff;
   assign sum_q_out = sum_q_ff;

endmodule

FILE: rtl/nco_mix_down_fir_core.sv
// A request beat is taken only in the idle state: the next sample waits until this one
// has passed the 16-step rotator, the mixer and the partial sum rippling through the
// TAP_DEPTH tap cells, and until the output register can take its result.
// A finished result waits in the output register while the next sample is taken.
// Synchronous active-high reset: phase 0, history zero, tap 0 = 1.0, one tap in use.
module nco_mix_down_fir_core #(
   parameter int TAP_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   nmf_req_if.sink   req_bus,
   nmf_rsp_if.source rsp_bus,
   nmf_csr_if.sink   csr_bus
);
   import nmf_pkg::*;

   localparam int ACC_W     = SAMPLE_W + COEF_W + $clog2(TAP_DEPTH);
   localparam int CNT_W     = $clog2(TAP_DEPTH + 2);
   localparam int FIR_SHIFT = COEF_W - 2;
   localparam logic [CNT_W-1:0] FIR_LAST = CNT_W'(TAP_DEPTH + 1);
   localparam logic signed [ACC_W:0] FIR_ROUND = (ACC_W + 1)'(2 ** (FIR_SHIFT - 1));

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PHASE = 3'd1;
   localparam logic [2:0] S_OSC   = 3'd2;
   localparam logic [2:0] S_MIX   = 3'd3;
   localparam logic [2:0] S_FIR   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [PHASE_W-1:0]     phase_step_ff, phase_step_in;
   logic [TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic [COEF_SEL_W-1:0]  coef_sel_ff, coef_sel_in;
   coef_wr_type            coef_wr_ff, coef_wr_in;
   logic [PHASE_W-1:0]     phase_acc_ff, phase_acc_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   cplx_type               smp_ff, smp_in;
   logic                   start_ff, start_in;
   logic [CNT_W-1:0]       fir_cnt_ff, fir_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sample_type             out_i_ff, out_i_in;
   sample_type             out_q_ff, out_q_in;

   logic                   req_beat;
   logic                   csr_beat;
   logic                   rsp_beat;
   logic [PHASE_W-1:0]     start_phase;
   logic                   cordic_start;
   logic                   cordic_done;
   cordic_val_type         cos_val;
   cordic_val_type         sin_val;
   logic                   mix_start;
   logic                   mix_valid;
   cplx_type               mix;
   logic                   shift_en;
   logic                   fir_done;
   logic signed [ACC_W:0]  fir_rnd_i;
   logic signed [ACC_W:0]  fir_rnd_q;

   cplx_type               x_chain [0:TAP_DEPTH];
   logic signed [ACC_W-1:0] sum_i_chain [0:TAP_DEPTH];
   logic signed [ACC_W-1:0] sum_q_chain [0:TAP_DEPTH];

   // Handshakes.
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_beat      = csr_bus.valid && csr_bus.ready;
   assign rsp_beat      = rsp_valid_ff && rsp_bus.ready;

   // Block start phase: step times sample number, modulo one turn.
   assign start_phase = phase_step_ff * req_bus.sample_index;

   // Control register writes.
   always_comb begin
      phase_step_in = phase_step_ff;
      tap_count_in  = tap_count_ff;
      coef_sel_in   = coef_sel_ff;
      coef_wr_in    = '{en: 1'b0, sel: coef_sel_ff,
                        value: coef_type'(csr_bus.data[COEF_W-1:0])};
      if (csr_beat) begin
         unique case (csr_bus.index)
            REG_PHASE_STEP: phase_step_in = csr_bus.data[PHASE_W-1:0];
            REG_TAP_COUNT:  tap_count_in  = csr_bus.data[TAP_COUNT_W-1:0];
            REG_COEF_SEL:   coef_sel_in   = csr_bus.data[COEF_SEL_W-1:0];
            REG_COEF_VALUE: coef_wr_in.en = 1'b1;
            default: ;
         endcase
      end
   end

   // Sample sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_acc_in = phase_acc_ff;
      phase_in     = phase_ff;
      smp_in       = smp_ff;
      start_in     = start_ff;
      fir_cnt_in   = fir_cnt_ff;
      cordic_start = 1'b0;
      mix_start    = 1'b0;
      shift_en     = 1'b0;
      fir_done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               smp_in.re = req_bus.sample_i;
               smp_in.im = req_bus.sample_q;
               start_in  = req_bus.block_start;
               phase_in  = req_bus.block_start ? start_phase : phase_acc_ff;
               state_in  = S_PHASE;
            end
         end
         S_PHASE: begin
            cordic_start = 1'b1;
            phase_acc_in = phase_ff + phase_step_ff;
            state_in     = S_OSC;
         end
         S_OSC: begin
            if (cordic_done) begin
               mix_start = 1'b1;
               state_in  = S_MIX;
            end
         end
         S_MIX: begin
            if (mix_valid) begin
               shift_en   = 1'b1;
               fir_cnt_in = '0;
               state_in   = S_FIR;
            end
         end
         S_FIR: begin
            if (fir_cnt_ff != FIR_LAST) begin
               fir_cnt_in = fir_cnt_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_bus.ready) begin
               fir_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Final rounding of the tap sum and the output register.
   always_comb begin
      fir_rnd_i    = (ACC_W + 1)'(sum_i_chain[TAP_DEPTH]) + FIR_ROUND;
      fir_rnd_q    = (ACC_W + 1)'(sum_q_chain[TAP_DEPTH]) + FIR_ROUND;
      out_i_in     = out_i_ff;
      out_q_in     = out_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_beat;
      if (fir_done) begin
         out_i_in     = sat_sample(64'(fir_rnd_i >>> FIR_SHIFT));
         out_q_in     = sat_sample(64'(fir_rnd_q >>> FIR_SHIFT));
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      smp_ff     <= smp_in;
      start_ff   <= start_in;
      fir_cnt_ff <= fir_cnt_in;
      out_i_ff   <= out_i_in;
      out_q_ff   <= out_q_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_step_ff <= '0;
         tap_count_ff  <= TAP_COUNT_W'(1);
         coef_sel_ff   <= '0;
         coef_wr_ff    <= '{en: 1'b0, sel: '0, value: '0};
         phase_acc_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_step_ff <= phase_step_in;
         tap_count_ff  <= tap_count_in;
         coef_sel_ff   <= coef_sel_in;
         coef_wr_ff    <= coef_wr_in;
         phase_acc_ff  <= phase_acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Oscillator.
   nmf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .phase   (phase_ff),
      .done    (cordic_done),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   // Conjugate mixer.
   nmf_mixer u_mixer (
      .clock   (clock),
      .reset   (reset),
      .start   (mix_start),
      .smp     (smp_ff),
      .cos_val (cos_val),
      .sin_val (sin_val),
      .valid   (mix_valid),
      .mix     (mix)
   );

   // Tap chain: history moves one way, the partial sum ripples the same way.
   assign x_chain[0]     = mix;
   assign sum_i_chain[0] = '0;
   assign sum_q_chain[0] = '0;

   for (genvar k = 0; k < TAP_DEPTH; k++) begin : g_tap
      nmf_tap_cell #(
         .IDX   (k),
         .ACC_W (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .clear     ((k == 0) ? 1'b0 : start_ff),
         .x_in      (x_chain[k]),
         .x_out     (x_chain[k+1]),
         .coef_wr   (coef_wr_ff),
         .tap_count (tap_count_ff),
         .sum_i_in  (sum_i_chain[k]),
         .sum_q_in  (sum_q_chain[k]),
         .sum_i_out (sum_i_chain[k+1]),
         .sum_q_out (sum_q_chain[k+1])
      );
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_i = out_i_ff;
   assign rsp_bus.out_q = out_q_ff;

`ifndef SYNTHESIS
   // The rotator only finishes while the sequencer waits for it.
   a_cordic_done_in_osc: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_OSC)
      else $error("oscillator result arrived outside its wait state");

   // The mixer only delivers while the sequencer waits for it.
   a_mix_in_mix: assert property (@(posedge clock) disable iff (reset)
      mix_valid |-> state_ff == S_MIX)
      else $error("mixer result arrived outside its wait state");

   // The ripple counter never runs past the end of the tap chain.
   a_fir_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIR |-> fir_cnt_ff <= FIR_LAST)
      else $error("tap chain counter ran past its end");

   // A new result is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fir_done |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result register overwritten while full");
`endif

endmodule
